FILE: rtl/utf8d_pkg.sv
package utf8d_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;
    localparam int unsigned RemW  = 2;
    localparam int unsigned ContW = 6;
    localparam int unsigned TDataOutW = 24;

    localparam logic [ByteW-1:0] LeadMask4  = 8'b1111_1000;
    localparam logic [ByteW-1:0] LeadMask3  = 8'b1111_0000;
    localparam logic [ByteW-1:0] LeadMask2  = 8'b1110_0000;
    localparam logic [ByteW-1:0] LeadCode4  = 8'b1111_0000;
    localparam logic [ByteW-1:0] LeadCode3  = 8'b1110_0000;
    localparam logic [ByteW-1:0] LeadCode2  = 8'b1100_0000;
    localparam logic [ByteW-1:0] PayMask4   = 8'b0000_0111;
    localparam logic [ByteW-1:0] PayMask3   = 8'b0000_1111;
    localparam logic [ByteW-1:0] PayMask2   = 8'b0001_1111;
    localparam logic [ByteW-1:0] ContMask   = 8'b0011_1111;

    localparam logic [RemW-1:0] RemIdle  = 2'd0;
    localparam logic [RemW-1:0] RemOne   = 2'd1;
    localparam logic [RemW-1:0] RemTwo   = 2'd2;
    localparam logic [RemW-1:0] RemThree = 2'd3;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             last_byte;
    } t_byte_word;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           ends_text;
    } t_cp_word;

endpackage

FILE: rtl/utf8_byte_stream_decoder_unit.sv
// channel   | dir | tdata bits                   | tlast
// ----------+-----+------------------------------+-----------
// s (bytes) | in  | [7:0] data_byte              | last_byte
// m (codes) | out | [20:0] code_point, [23:21] 0 | ends_text
//
// One byte is accepted per cycle while m does not stall; a code point that a
// byte completes passes the input register, then decode and the result register.
// i_rst_n is synchronous, active low; it clears the valid flags and the
// sequence state. A stall on m backs up into the input register and then s.
module utf8_byte_stream_decoder_unit
    import utf8d_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [ByteW-1:0]     i_s_tdata,   // [7:0] data_byte
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [TDataOutW-1:0] o_m_tdata,   // [20:0] code_point, [23:21] zero
    output logic                 o_m_tlast
);

    t_byte_word in_word;
    t_byte_word reg_word;
    t_cp_word   out_word;
    logic       reg_valid;
    logic       dec_ready;

    assign in_word.data_byte = i_s_tdata;
    assign in_word.last_byte = i_s_tlast;

    utf8d_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_word  (in_word),
        .o_valid (reg_valid),
        .i_ready (dec_ready),
        .o_word  (reg_word)
    );

    utf8d_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (reg_valid),
        .o_ready (dec_ready),
        .i_word  (reg_word),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_word  (out_word)
    );

    assign o_m_tdata = {{(TDataOutW-CpW){1'b0}}, out_word.code_point};
    assign o_m_tlast = out_word.ends_text;

endmodule

FILE: rtl/utf8d_in_reg.sv
module utf8d_in_reg
    import utf8d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_byte_word i_word,
    output logic       o_valid,
    input  logic       i_ready,
    output t_byte_word o_word
);

    logic       r_valid;
    logic       n_valid;
    t_byte_word r_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // hold the word while the decoder stalls
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

FILE: rtl/utf8d_decode.sv
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_byte_word i_word,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cp_word   o_word
);

    logic [RemW-1:0] r_rem;
    logic [RemW-1:0] n_rem;
    logic [CpW-1:0]  r_partial;
    logic [CpW-1:0]  n_partial;
    logic            r_out_valid;
    logic            n_out_valid;
    t_cp_word        r_out;
    logic            emit;
    t_cp_word        emit_word;
    logic            take;
    logic [CpW-1:0]  shifted;
    logic [ByteW-1:0] b;

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;
    assign b       = i_word.data_byte;
    assign shifted = {r_partial[CpW-ContW-1:0], b[ContW-1:0]};

    always_comb begin
        n_rem     = r_rem;
        n_partial = r_partial;
        emit      = 1'b0;
        emit_word.code_point = shifted;
        emit_word.ends_text  = i_word.last_byte;
        if (r_rem == RemIdle) begin
            emit_word.code_point = {{(CpW-ByteW){1'b0}}, b};
            if (!b[ByteW-1]) begin
                emit = 1'b1;
            end else if ((b & LeadMask4) == LeadCode4) begin
                n_partial = {{(CpW-ByteW){1'b0}}, b & PayMask4};
                n_rem     = RemThree;
            end else if ((b & LeadMask3) == LeadCode3) begin
                n_partial = {{(CpW-ByteW){1'b0}}, b & PayMask3};
                n_rem     = RemTwo;
            end else if ((b & LeadMask2) == LeadCode2) begin
                n_partial = {{(CpW-ByteW){1'b0}}, b & PayMask2};
                n_rem     = RemOne;
            end
        end else begin
            n_partial = shifted;
            n_rem     = r_rem - RemOne;
            if (r_rem == RemOne) begin
                emit      = 1'b1;
                n_partial = '0;
            end
        end
        // drop a sequence cut short by the end of the text
        if (i_word.last_byte && !emit) begin
            n_rem     = RemIdle;
            n_partial = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ready) begin
            n_out_valid = take && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= RemIdle;
            r_partial   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (take) begin
                r_rem     <= n_rem;
                r_partial <= n_partial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out <= emit_word;
        end
    end

endmodule

FILE: sim/utf8_byte_stream_decoder_unit_test.sv
module utf8_byte_stream_decoder_unit_test;
    import utf8d_pkg::*;

    localparam int unsigned QuietLimit = 4000;
    localparam int unsigned PhaseBytes = 460;
    localparam int unsigned PlanRows   = 24;

    typedef enum logic [1:0] {
        ExpPredicted,
        ExpSilent,
        ExpCodePoint
    } t_exp_kind;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             last_byte;
        t_exp_kind        kind;
        logic [CpW-1:0]   code_point;
        logic             ends_text;
    } t_plan_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [ByteW-1:0]     i_s_tdata  = '0;    // [7:0] data_byte
    logic                 i_s_tlast  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [TDataOutW-1:0] o_m_tdata;          // [20:0] code_point, [23:21] zero
    logic                 o_m_tlast;

    t_exp_kind      pin_kind = ExpPredicted;
    t_cp_word       pin_word = '0;

    logic [RemW-1:0] seq_left = RemIdle;
    logic [CpW-1:0]  seq_bits = '0;
    t_cp_word        cp_due[$];
    t_cp_word        due_word;
    t_cp_word        new_word;
    logic            new_hit;

    int unsigned send_idle_pct = 12;
    int unsigned recv_stall_pct = 69;
    int unsigned bytes_sent = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    t_plan_row plan [PlanRows] = '{
        '{8'h00, 1'b0, ExpCodePoint, 21'h000000, 1'b0},
        '{8'h7F, 1'b1, ExpCodePoint, 21'h00007F, 1'b1},
        '{8'h80, 1'b0, ExpSilent,    21'h0,      1'b0},
        '{8'hF8, 1'b0, ExpSilent,    21'h0,      1'b0},
        '{8'hFF, 1'b1, ExpSilent,    21'h0,      1'b0},
        '{8'hC0, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'h80, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'hDF, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'hBF, 1'b0, ExpCodePoint, 21'h0007FF, 1'b0},
        '{8'hE0, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'h80, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'h80, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'hF7, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'hBF, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'hBF, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'hBF, 1'b0, ExpCodePoint, 21'h1FFFFF, 1'b0},
        '{8'hC3, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'h29, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'hF0, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'h90, 1'b1, ExpSilent,    21'h0,      1'b0},
        '{8'hE5, 1'b1, ExpSilent,    21'h0,      1'b0},
        '{8'hC2, 1'b0, ExpPredicted, 21'h0,      1'b0},
        '{8'hA9, 1'b1, ExpCodePoint, 21'h0000A9, 1'b1},
        '{8'h41, 1'b0, ExpPredicted, 21'h0,      1'b0}
    };

    utf8_byte_stream_decoder_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void decode_byte(input logic [ByteW-1:0] b, input logic ends,
                                        output logic hit, output t_cp_word word);
        hit  = 1'b0;
        word = '0;
        if (seq_left == RemIdle) begin
            if (!b[ByteW-1]) begin
                hit = 1'b1;
                word.code_point = CpW'(b);
                word.ends_text  = ends;
            end else if ((b & LeadMask4) == LeadCode4) begin
                seq_bits = CpW'(b & PayMask4);
                seq_left = RemThree;
            end else if ((b & LeadMask3) == LeadCode3) begin
                seq_bits = CpW'(b & PayMask3);
                seq_left = RemTwo;
            end else if ((b & LeadMask2) == LeadCode2) begin
                seq_bits = CpW'(b & PayMask2);
                seq_left = RemOne;
            end
            if (ends && !hit) begin
                seq_left = RemIdle;
                seq_bits = '0;
            end
        end else begin
            seq_bits = (seq_bits << ContW) | CpW'(b & ContMask);
            seq_left = seq_left - RemOne;
            if (seq_left == RemIdle) begin
                hit = 1'b1;
                word.code_point = seq_bits;
                word.ends_text  = ends;
                seq_bits = '0;
            end else if (ends) begin
                seq_left = RemIdle;
                seq_bits = '0;
            end
        end
    endfunction

    function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected %h, got %h", what, want, got);
    endfunction

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (cp_due.size() == 0) begin
                    flag_mismatch("code point with none due", 32'h0, 32'(o_m_tdata));
                end else begin
                    due_word = cp_due.pop_front();
                    if (o_m_tdata[CpW-1:0] !== due_word.code_point)
                        flag_mismatch("code_point", 32'(due_word.code_point),
                                      32'(o_m_tdata[CpW-1:0]));
                    if (o_m_tdata[TDataOutW-1:CpW] !== '0)
                        flag_mismatch("tdata pad", 32'h0, 32'(o_m_tdata[TDataOutW-1:CpW]));
                    if (o_m_tlast !== due_word.ends_text)
                        flag_mismatch("ends_text", 32'(due_word.ends_text), 32'(o_m_tlast));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                decode_byte(i_s_tdata, i_s_tlast, new_hit, new_word);
                case (pin_kind)
                    ExpSilent: begin
                        new_hit = 1'b0;
                    end
                    ExpCodePoint: begin
                        new_hit  = 1'b1;
                        new_word = pin_word;
                    end
                    default: ;
                endcase
                if (new_hit)
                    cp_due.push_back(new_word);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("utf8_byte_stream_decoder_unit_test: done, errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [ByteW-1:0] b, input logic ends,
                             input t_exp_kind kind, input t_cp_word word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= ends;
        pin_kind   <= kind;
        pin_word   <= word;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (cp_due.size() != 0);
    endtask

    task automatic send_random_unit();
        logic [ByteW-1:0] run[$];
        int unsigned pick;
        int unsigned conts;
        int unsigned k;
        logic cut_short;
        logic ends;
        pick = $urandom_range(99);
        cut_short = (pick >= 93);
        if (pick < 40) begin
            run.push_back({1'b0, 7'($urandom)});
        end else if (pick >= 80 && pick < 86) begin
            if ($urandom_range(1))
                run.push_back({2'b10, 6'($urandom)});
            else
                run.push_back({5'b11111, 3'($urandom)});
        end else begin
            conts = (pick < 55) ? 1 : (pick < 68) ? 2 : (pick < 80) ? 3 : $urandom_range(1, 3);
            case (conts)
                1: run.push_back({3'b110, 5'($urandom)});
                2: run.push_back({4'b1110, 4'($urandom)});
                default: run.push_back({5'b11110, 3'($urandom)});
            endcase
            if (cut_short)
                conts = $urandom_range(0, conts - 1);
            for (k = 0; k < conts; k++) begin
                if (pick >= 86 && pick < 93)
                    run.push_back(8'($urandom));
                else
                    run.push_back({2'b10, 6'($urandom)});
            end
        end
        for (k = 0; k < run.size(); k++) begin
            ends = (k == run.size() - 1) && (cut_short || $urandom_range(9) == 0);
            send_byte(run[k], ends, ExpPredicted, '0);
        end
    endtask

    initial begin
        int unsigned row;
        int unsigned phase;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (row = 0; row < PlanRows; row++)
            send_byte(plan[row].data_byte, plan[row].last_byte, plan[row].kind,
                      {plan[row].code_point, plan[row].ends_text});
        hold_until_drained();
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 12; recv_stall_pct = 69; end
                1: begin send_idle_pct = 69; recv_stall_pct = 12; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            while (bytes_sent < PlanRows + (phase + 1) * PhaseBytes)
                send_random_unit();
            hold_until_drained();
        end
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("utf8_byte_stream_decoder_unit_test: done, clean");
        else
            $display("utf8_byte_stream_decoder_unit_test: done, errors");
        $finish;
    end

endmodule
